/* hw/rtl/lnsc_pkg.sv */
// Shared types and constants of the letterbox nearest-neighbor scaler.
package lnsc_pkg;

    // Field widths.
    localparam int DIM_W      = 13;
    localparam int OFS_W      = 12;
    localparam int STRIDE_W   = 15;
    localparam int ADDR_W     = 28;
    localparam int PIX_W      = 32;
    localparam int IDX_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;

    // The shared divider takes a product of two sizes over one size.
    localparam int DIV_W      = 2 * DIM_W;
    localparam int DEN_W      = DIM_W;

    // Write address product: (row + offset) times stride.
    localparam int WPROD_W    = DIM_W + 1 + STRIDE_W;

    localparam logic [PIX_W-1:0] ALPHA_OPAQUE = 32'hFF00_0000;

    // Operation codes of an input item.
    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BASE = 3'd3;

    // Configuration reset values.
    localparam logic [DIM_W-1:0]    DEST_WIDTH_RST  = 13'd800;
    localparam logic [DIM_W-1:0]    DEST_HEIGHT_RST = 13'd480;
    localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST  = 15'd3200;
    localparam logic [ADDR_W-1:0]   TARGET_BASE_RST = 28'd0;

    typedef struct packed {
        logic               op;
        logic [DIM_W-1:0]   source_width;
        logic [DIM_W-1:0]   source_height;
        logic [PIX_W-1:0]   pixel_value;
    } t_in_item;

    typedef struct packed {
        logic               write_valid;
        logic [ADDR_W-1:0]  write_offset;
        logic [PIX_W-1:0]   write_pixel;
        logic               read_valid;
        logic [IDX_W-1:0]   read_index;
        logic               last;
        logic               rejected;
    } t_out_item;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RUN,
        ST_DECODE,
        ST_CMP,
        ST_DIVS,
        ST_CHECK,
        ST_DIVC,
        ST_DIVR,
        ST_ADDR,
        ST_EMIT
    } t_state;

    // Datapath operations.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LATCH,
        DP_MUL,
        DP_CMP,
        DP_FIT,
        DP_COLDIV,
        DP_ROWDIV,
        DP_SETUP,
        DP_STEP,
        DP_ADDR,
        DP_EMIT
    } t_dp_op;

    // Kind of result item to build.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_REJECT,
        RES_EMPTY,
        RES_START,
        RES_PIXEL,
        RES_FINAL
    } t_res_kind;

    typedef struct packed {
        t_dp_op    op;
        t_res_kind kind;
    } t_cmd;

    typedef struct packed {
        logic op_pixel;
        logic size_zero;
        logic empty;
        logic div_done;
        logic last_pix;
    } t_status;

endpackage

/* hw/rtl/lnsc_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all start divisions.
module lnsc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lnsc_pkg::DIV_W-1:0]   i_dividend,
    input  logic [lnsc_pkg::DEN_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [lnsc_pkg::DIV_W-1:0]   o_quot,
    output logic [lnsc_pkg::DEN_W-1:0]   o_rem
);
    import lnsc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_W - 1);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_div;

    logic [DEN_W:0]   partial;
    logic             fits;
    logic [DEN_W:0]   diff;

    // One trial subtraction per cycle.
    always_comb begin
        partial = {r_rem, r_quot[DIV_W-1]};
        fits    = (partial >= {1'b0, r_div});
        diff    = partial - {1'b0, r_div};
    end

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST_STEP) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Quotient shifts in from the right as the dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_run) begin
            r_quot <= {r_quot[DIV_W-2:0], fits};
            r_rem  <= fits ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

/* hw/rtl/lnsc_dp.sv */
// Datapath: configuration registers, fit arithmetic, raster steppers and result register.
module lnsc_dp #(
    parameter int MAX_SCALED_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lnsc_pkg::t_cmd                    i_cmd,
    output lnsc_pkg::t_status                 o_status,
    input  lnsc_pkg::t_in_item                i_in_data,
    input  logic                              i_cfg_we,
    input  logic [lnsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lnsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output lnsc_pkg::t_out_item               o_out_data
);
    import lnsc_pkg::*;

    localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAX_SCALED_WIDTH);

    // Configuration registers.
    logic [DIM_W-1:0]    r_dest_w;
    logic [DIM_W-1:0]    r_dest_h;
    logic [STRIDE_W-1:0] r_row_stride;
    logic [ADDR_W-1:0]   r_target_base;

    // Latched item.
    logic                r_op;
    logic [PIX_W-1:0]    r_pix;
    logic [DIM_W-1:0]    r_sw;
    logic [DIM_W-1:0]    r_sh;

    // Fit.
    logic [DIV_W-1:0]    r_prod_a;
    logic [DIV_W-1:0]    r_prod_b;
    logic                r_wide;
    logic [DIM_W-1:0]    r_scaled_w;
    logic [DIM_W-1:0]    r_scaled_h;
    logic [OFS_W-1:0]    r_off_x;
    logic [OFS_W-1:0]    r_off_y;

    // Source step per destination step: quotient and remainder.
    logic [DIM_W-1:0]    r_cq;
    logic [DIM_W-1:0]    r_cr;
    logic [DIM_W-1:0]    r_rq;
    logic [DIM_W-1:0]    r_rr;

    // Raster position.
    logic [DIM_W-1:0]    r_dst_col;
    logic [DIM_W-1:0]    r_dst_row;
    logic [DIM_W-1:0]    r_src_col;
    logic [DIM_W-1:0]    r_src_col_rem;
    logic [DIM_W-1:0]    r_src_row;
    logic [DIM_W-1:0]    r_src_row_rem;
    logic                r_last;

    // Address stage.
    logic [WPROD_W-1:0]  r_wprod;
    logic [DIM_W:0]      r_xterm;
    logic [PIX_W-1:0]    r_wpix;
    logic [ADDR_W-1:0]   r_wofs;
    logic [IDX_W-1:0]    r_idx;

    t_out_item           r_out;
    t_out_item           n_out;

    // Divider port.
    logic                div_start;
    logic [DIV_W-1:0]    div_dividend;
    logic [DEN_W-1:0]    div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_quot;
    logic [DEN_W-1:0]    div_rem;

    logic                wide_n;
    logic [DIM_W-1:0]    fit_q;
    logic [DIM_W-1:0]    fit_w;
    logic [DIM_W-1:0]    fit_h;
    logic [DIM_W-1:0]    diff_x;
    logic [DIM_W-1:0]    diff_y;

    logic [DIM_W:0]      col_next;
    logic [DIM_W:0]      row_next;
    logic                col_wrap;
    logic                blit_done;
    logic [DIM_W:0]      c_sum;
    logic                c_carry;
    logic [DIM_W-1:0]    c_rem;
    logic [DIM_W-1:0]    c_src;
    logic [DIM_W:0]      r_sum;
    logic                r_carry;
    logic [DIM_W-1:0]    r_rem_n;
    logic [DIM_W-1:0]    r_src_n;

    logic [DIM_W:0]      w_row;
    logic [WPROD_W-1:0]  w_prod;
    logic [DIV_W-1:0]    i_prod;

    lnsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_w      <= DEST_WIDTH_RST;
            r_dest_h      <= DEST_HEIGHT_RST;
            r_row_stride  <= ROW_STRIDE_RST;
            r_target_base <= TARGET_BASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEST_WIDTH:  r_dest_w      <= i_cfg_data[DIM_W-1:0];
                CFG_DEST_HEIGHT: r_dest_h      <= i_cfg_data[DIM_W-1:0];
                CFG_ROW_STRIDE:  r_row_stride  <= i_cfg_data[STRIDE_W-1:0];
                CFG_TARGET_BASE: r_target_base <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    // Divider operand selection.
    always_comb begin
        wide_n       = (r_prod_a > r_prod_b);
        div_start    = 1'b0;
        div_dividend = r_prod_a;
        div_divisor  = r_sh;
        case (i_cmd.op)
            DP_CMP: begin
                // Width-limited: dest_width*sh/sw, else dest_height*sw/sh.
                div_start    = 1'b1;
                div_dividend = wide_n ? r_prod_b : r_prod_a;
                div_divisor  = wide_n ? r_sw : r_sh;
            end
            DP_COLDIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(r_sw);
                div_divisor  = r_scaled_w;
            end
            DP_ROWDIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(r_sh);
                div_divisor  = r_scaled_h;
            end
            default: ;
        endcase
    end

    // Scaled size and centering offsets; offsets use the width before the cap.
    always_comb begin
        fit_q  = div_quot[DIM_W-1:0];
        fit_w  = r_wide ? r_dest_w : fit_q;
        fit_h  = r_wide ? fit_q : r_dest_h;
        diff_x = r_dest_w - fit_w;
        diff_y = r_dest_h - fit_h;
    end

    // Raster steppers: destination counters and source remainder steppers.
    always_comb begin
        col_next  = {1'b0, r_dst_col} + 1'b1;
        row_next  = {1'b0, r_dst_row} + 1'b1;
        col_wrap  = (col_next >= {1'b0, r_scaled_w});
        blit_done = col_wrap && (row_next >= {1'b0, r_scaled_h});

        c_sum    = {1'b0, r_src_col_rem} + {1'b0, r_cr};
        c_carry  = (c_sum >= {1'b0, r_scaled_w});
        c_rem    = c_carry ? DIM_W'(c_sum - {1'b0, r_scaled_w}) : c_sum[DIM_W-1:0];
        c_src    = r_src_col + r_cq + DIM_W'(c_carry);

        r_sum    = {1'b0, r_src_row_rem} + {1'b0, r_rr};
        r_carry  = (r_sum >= {1'b0, r_scaled_h});
        r_rem_n  = r_carry ? DIM_W'(r_sum - {1'b0, r_scaled_h}) : r_sum[DIM_W-1:0];
        r_src_n  = r_src_row + r_rq + DIM_W'(r_carry);
    end

    // Destination row term and source row term.
    always_comb begin
        w_row  = {1'b0, r_dst_row} + {2'b00, r_off_y};
        w_prod = WPROD_W'(w_row) * WPROD_W'(r_row_stride);
        i_prod = DIV_W'(r_src_row) * DIV_W'(r_sw);
    end

    // Result item built from the kind the controller gives.
    always_comb begin
        n_out = '0;
        case (i_cmd.kind)
            RES_REJECT: n_out.rejected = 1'b1;
            RES_EMPTY:  n_out.last = 1'b1;
            RES_START: begin
                n_out.read_valid = 1'b1;
                n_out.read_index = r_idx;
            end
            RES_PIXEL: begin
                n_out.write_valid  = 1'b1;
                n_out.write_offset = r_wofs;
                n_out.write_pixel  = r_wpix;
                n_out.read_valid   = 1'b1;
                n_out.read_index   = r_idx;
            end
            RES_FINAL: begin
                n_out.write_valid  = 1'b1;
                n_out.write_offset = r_wofs;
                n_out.write_pixel  = r_wpix;
                n_out.last         = 1'b1;
            end
            default: ;
        endcase
    end

    // Datapath registers, one operation per cycle.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LATCH: begin
                r_op  <= i_in_data.op;
                r_pix <= i_in_data.pixel_value;
                if (i_in_data.op == OP_START) begin
                    r_sw <= i_in_data.source_width;
                    r_sh <= i_in_data.source_height;
                end
            end
            DP_MUL: begin
                r_prod_a <= DIV_W'(r_sw) * DIV_W'(r_dest_h);
                r_prod_b <= DIV_W'(r_sh) * DIV_W'(r_dest_w);
            end
            DP_CMP: r_wide <= wide_n;
            DP_FIT: begin
                r_off_x    <= diff_x[DIM_W-1:1];
                r_off_y    <= diff_y[DIM_W-1:1];
                r_scaled_w <= (fit_w > MAX_W) ? MAX_W : fit_w;
                r_scaled_h <= fit_h;
            end
            DP_ROWDIV: begin
                r_cq <= div_quot[DIM_W-1:0];
                r_cr <= div_rem;
            end
            DP_SETUP: begin
                r_rq          <= div_quot[DIM_W-1:0];
                r_rr          <= div_rem;
                r_dst_col     <= '0;
                r_dst_row     <= '0;
                r_src_col     <= '0;
                r_src_col_rem <= '0;
                r_src_row     <= '0;
                r_src_row_rem <= '0;
            end
            DP_STEP: begin
                r_wprod <= w_prod;
                r_xterm <= {1'b0, r_dst_col} + {2'b00, r_off_x};
                r_wpix  <= r_pix | ALPHA_OPAQUE;
                r_last  <= blit_done;
                if (blit_done) begin
                    r_dst_col     <= '0;
                    r_dst_row     <= '0;
                    r_src_col     <= '0;
                    r_src_col_rem <= '0;
                    r_src_row     <= '0;
                    r_src_row_rem <= '0;
                end else if (col_wrap) begin
                    r_dst_col     <= '0;
                    r_src_col     <= '0;
                    r_src_col_rem <= '0;
                    r_dst_row     <= row_next[DIM_W-1:0];
                    r_src_row     <= r_src_n;
                    r_src_row_rem <= r_rem_n;
                end else begin
                    r_dst_col     <= col_next[DIM_W-1:0];
                    r_src_col     <= c_src;
                    r_src_col_rem <= c_rem;
                end
            end
            DP_ADDR: begin
                r_wofs <= r_target_base + r_wprod[ADDR_W-1:0] + ADDR_W'({r_xterm, 2'b00});
                r_idx  <= i_prod[IDX_W-1:0] + IDX_W'(r_src_col);
            end
            DP_EMIT: r_out <= n_out;
            default: ;
        endcase
    end

    // Status toward the controller.
    always_comb begin
        o_status.op_pixel  = (r_op == OP_PIXEL);
        o_status.size_zero = (r_sw == '0) || (r_sh == '0);
        o_status.empty     = (r_scaled_w == '0) || (r_scaled_h == '0);
        o_status.div_done  = div_done;
        o_status.last_pix  = r_last;
    end

    assign o_out_data = r_out;

endmodule

/* hw/rtl/lnsc_ctrl.sv */
// Controller: sequences start fits and pixel writes, and owns both handshakes.
module lnsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  lnsc_pkg::t_status i_status,
    output lnsc_pkg::t_cmd    o_cmd
);
    import lnsc_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_res_kind r_kind;
    t_res_kind n_kind;
    logic      r_busy;
    logic      n_busy;
    logic      r_out_valid;
    logic      n_out_valid;
    logic      emit;
    t_cmd      c_cmd;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kind      <= RES_NONE;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_busy     = r_busy;
        emit       = 1'b0;
        c_cmd.op   = DP_NOP;
        c_cmd.kind = r_kind;
        case (r_state)
            ST_IDLE, ST_RUN: begin
                if (i_in_valid) begin
                    c_cmd.op = DP_LATCH;
                    n_busy   = (r_state == ST_RUN);
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!i_status.op_pixel) begin
                    // A start abandons any blit in progress.
                    n_busy = 1'b0;
                    if (i_status.size_zero) begin
                        n_kind  = RES_REJECT;
                        n_state = ST_EMIT;
                    end else begin
                        c_cmd.op = DP_MUL;
                        n_state  = ST_CMP;
                    end
                end else if (r_busy) begin
                    c_cmd.op = DP_STEP;
                    n_kind   = RES_PIXEL;
                    n_state  = ST_ADDR;
                end else begin
                    n_kind  = RES_NONE;
                    n_state = ST_EMIT;
                end
            end
            ST_CMP: begin
                c_cmd.op = DP_CMP;
                n_state  = ST_DIVS;
            end
            ST_DIVS: begin
                if (i_status.div_done) begin
                    c_cmd.op = DP_FIT;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.empty) begin
                    n_kind  = RES_EMPTY;
                    n_state = ST_EMIT;
                end else begin
                    c_cmd.op = DP_COLDIV;
                    n_state  = ST_DIVC;
                end
            end
            ST_DIVC: begin
                if (i_status.div_done) begin
                    c_cmd.op = DP_ROWDIV;
                    n_state  = ST_DIVR;
                end
            end
            ST_DIVR: begin
                if (i_status.div_done) begin
                    c_cmd.op = DP_SETUP;
                    n_kind   = RES_START;
                    n_state  = ST_ADDR;
                end
            end
            ST_ADDR: begin
                c_cmd.op = DP_ADDR;
                if (r_kind == RES_PIXEL && i_status.last_pix) begin
                    n_kind = RES_FINAL;
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // Wait until the result register is free.
                if (!r_out_valid || i_out_ready) begin
                    c_cmd.op = DP_EMIT;
                    emit     = 1'b1;
                    if (r_kind inside {RES_START, RES_PIXEL}) begin
                        n_state = ST_RUN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = emit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    // No item is taken while reset is held.
    assign o_in_ready  = i_rst_n && (r_state inside {ST_IDLE, ST_RUN});
    assign o_out_valid = r_out_valid;
    assign o_cmd       = c_cmd;

    // A result is never loaded over one that has not been taken.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_cmd.op == DP_EMIT) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while another is in work");

    // A start result that requests a pixel needs a nonempty scaled image.
    a_start_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_cmd.op == DP_EMIT && r_kind == RES_START) |-> !i_status.empty)
        else $error("pixel requested for an empty scaled image");

endmodule

/* hw/rtl/letterbox_nearest_scaler.sv */
// Top level of the letterbox nearest-neighbor scaler.
//
//   Channel   Direction  Handshake                   Payload
//   in        input      i_in_valid / o_in_ready     i_in_data (t_in_item)
//   out       output     o_out_valid / i_out_ready   o_out_data (t_out_item)
//   cfg       input      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A pixel item passes from acceptance to the next acceptance through latch,
// decode with the raster step and stride multiply, address and index add, result load.
// A start item runs three divisions in the shared divider: the fit, the column step
// and the row step; a rejected start or an idle pixel passes latch, decode and result load.
// Reset is synchronous and active low; configuration returns to its reset values.
// A stalled output holds the sequencer at the result load; configuration is ready
// whenever reset is released, and neither input channel is ready during reset.
module letterbox_nearest_scaler #(
    parameter int MAX_SCALED_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lnsc_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lnsc_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lnsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lnsc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lnsc_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = i_rst_n;

    lnsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    lnsc_dp #(
        .MAX_SCALED_WIDTH (MAX_SCALED_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule
